/* rtl/kuj_pkg.sv */
// ----------------------------------------------------------------------------
// kuj_pkg
// Shared types, codes and helpers for the Joseph-form Kalman update block.
// ----------------------------------------------------------------------------
`default_nettype none

package kuj_pkg;

    localparam int MAX_STATE_DEF = 8;
    localparam int MAX_MEAS_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;

    // reset value of the P_INIT configuration register
    localparam logic [30:0] P_INIT_RST = 31'd65536;

    // configuration register indexes
    localparam logic [1:0] CFG_P_INIT  = 2'd0;
    localparam logic [1:0] CFG_N_STATE = 2'd1;
    localparam logic [1:0] CFG_N_MEAS  = 2'd2;

    // command codes
    localparam logic [2:0] CMD_LOAD_Q  = 3'd0;
    localparam logic [2:0] CMD_LOAD_R  = 3'd1;
    localparam logic [2:0] CMD_LOAD_X  = 3'd2;
    localparam logic [2:0] CMD_LOAD_A  = 3'd3;
    localparam logic [2:0] CMD_LOAD_B  = 3'd4;
    localparam logic [2:0] CMD_RUN     = 3'd5;
    localparam logic [2:0] CMD_RESET_P = 3'd6;

    // regions of the matrix store; the first four are cleared after reset, P to its initial diagonal
    typedef enum logic [3:0] {
        REG_P, REG_Q, REG_R, REG_X, REG_A, REG_B, REG_PW, REG_AP,
        REG_S, REG_L, REG_Y, REG_Z, REG_IN, REG_IKH, REG_T, REG_KR
    } region_t;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_INIT_RD, ST_INIT_AC, ST_MAC_RD, ST_MAC_MUL,
        ST_MAC_ACC, ST_FIN, ST_DIAG_RD, ST_DS_GO, ST_DS_WAIT, ST_NEXT,
        ST_EMIT_RD, ST_EMIT_LD
    } state_t;

    typedef enum logic [3:0] {
        PH_PQ, PH_AP, PH_S, PH_CHOL, PH_FWD, PH_BWD, PH_INNOV, PH_XN,
        PH_IKH, PH_T, PH_KR, PH_PN
    } phase_t;

    typedef enum logic [1:0] {
        INIT_ZERO, INIT_A, INIT_AB, INIT_EYE
    } init_t;

    typedef enum logic [1:0] {
        FIN_STORE, FIN_CHOL, FIN_DIV
    } fin_t;

    typedef enum logic {
        DS_DIV, DS_SQRT
    } ds_mode_t;

    typedef struct packed {
        logic        start;
        ds_mode_t    mode;
        logic [31:0] num;
        logic [31:0] den;
    } ds_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } ds_rsp_t;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] r;
        if (!v[63] && (|v[62:31])) r = 32'h7fff_ffff;
        else if (v[63] && !(&v[62:31])) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/kuj_divsqrt.sv */
// ----------------------------------------------------------------------------
// kuj_divsqrt
// Shared radix-2 unit: fixed-point quotient with saturation, or integer
// square root of a value scaled up by the fraction bits. One bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kuj_divsqrt #(
    parameter int FRAC_BITS = kuj_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  kuj_pkg::ds_req_t req,
    output kuj_pkg::ds_rsp_t rsp
);
    import kuj_pkg::*;

    localparam int NW   = 32 + FRAC_BITS;
    localparam int SQN  = (NW + 1) / 2;
    localparam int SW   = 2 * SQN;
    localparam int RW   = (SQN + 2 > 33) ? SQN + 2 : 33;
    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    ds_mode_t        mode_reg;
    logic            neg_reg;
    logic [SW-1:0]   shf_reg;
    logic [RW-1:0]   rem_reg;
    logic [NW-1:0]   q_reg;
    logic [31:0]     den_reg;
    logic [31:0]     res_reg;

    logic [RW-1:0]   rem_sh;
    logic [RW-1:0]   sub_op;
    logic            fits;
    logic [CNTW-1:0] steps;
    logic [31:0]     mag;
    logic            ovf_p;
    logic            ovf_n;
    logic [31:0]     res_fin;
    logic            start_ok;

    assign start_ok = !busy_reg && req.start;
    assign mag      = req.num[31] ? (32'd0 - req.num) : req.num;

    always_comb
    begin
        if (mode_reg == DS_DIV)
        begin
            rem_sh = {rem_reg[RW-2:0], shf_reg[SW-1]};
            sub_op = RW'(den_reg);
            steps  = CNTW'(NW);
        end
        else
        begin
            rem_sh = {rem_reg[RW-3:0], shf_reg[SW-1:SW-2]};
            sub_op = {q_reg[RW-3:0], 2'b01};
            steps  = CNTW'(SQN);
        end
        fits  = rem_sh >= sub_op;
        ovf_p = |q_reg[NW-1:31];
        ovf_n = (|q_reg[NW-1:32]) || (q_reg[31] && (|q_reg[30:0]));
        if (mode_reg == DS_SQRT) res_fin = q_reg[31:0];
        else if (neg_reg) res_fin = ovf_n ? 32'h8000_0000 : (32'd0 - q_reg[31:0]);
        else res_fin = ovf_p ? 32'h7fff_ffff : q_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start_ok)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == steps)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNTW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_ok)
        begin
            mode_reg <= req.mode;
            neg_reg  <= (req.mode == DS_DIV) && req.num[31];
            den_reg  <= req.den;
            rem_reg  <= '0;
            q_reg    <= '0;
            if (req.mode == DS_DIV)
                shf_reg <= SW'({mag, {FRAC_BITS{1'b0}}}) << (SW - NW);
            else
                shf_reg <= SW'({req.num[30:0], {FRAC_BITS{1'b0}}});
        end
        else if (busy_reg)
        begin
            if (cnt_reg == steps)
            begin
                res_reg <= res_fin;
            end
            else
            begin
                rem_reg <= fits ? (rem_sh - sub_op) : rem_sh;
                q_reg   <= {q_reg[NW-2:0], fits};
                shf_reg <= (mode_reg == DS_DIV) ? (shf_reg << 1) : (shf_reg << 2);
            end
        end
    end

    assign rsp = '{done: done_reg, res: res_reg};

endmodule

`default_nettype wire

/* rtl/kalman_update_joseph_form.sv */
// ----------------------------------------------------------------------------
// kalman_update_joseph_form
// Fixed-point Kalman measurement update with Cholesky gain solve and
// Joseph-form covariance update, run by a sequencer over one shared MAC.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  s        in         s_tvalid/s_tready   s_tdata, s_tuser (command)
//  m        out        m_tvalid/m_tready   m_tdata, m_tlast, m_tuser (not_pd)
//  cfg      in         cfg_we              cfg_addr, cfg_wdata
//
//  after reset a clearing pass zeroes Q, R and x and sets P to the reset
//  p_init on its diagonal; s_tready is low meanwhile. a reset-P command
//  reruns the pass over P alone with the configured p_init. a run shares
//  the single 32x32 multiplier for every product term and the radix-2 unit
//  for each division and square root. results leave through one output
//  register; a stalled m side holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_update_joseph_form #(
    parameter int MAX_STATE = kuj_pkg::MAX_STATE_DEF,
    parameter int MAX_MEAS  = kuj_pkg::MAX_MEAS_DEF,
    parameter int FRAC_BITS = kuj_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [30:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row[2:0], col[5:3], value[37:6]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // index[2:0], estimate[34:3]
    output logic        m_tlast,
    output logic        m_tuser    // not_pd[0]
);
    import kuj_pkg::*;

    localparam int DIM   = (MAX_STATE > MAX_MEAS) ? MAX_STATE : MAX_MEAS;
    localparam int DB    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CW    = DB + 1;
    localparam int KW    = DB + 2;
    localparam int AW    = 4 + 2 * DB;
    localparam int DEPTH = 1 << AW;
    localparam int CLRW  = 2 + 2 * DB;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    function automatic logic [AW-1:0] ad(region_t rg, logic [KW-1:0] r, logic [KW-1:0] c);
        return {rg, r[DB-1:0], c[DB-1:0]};
    endfunction

    // registers
    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   o_reg, o_next;
    logic [CW-1:0]   mi_reg, mi_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [63:0]     acc_reg, acc_next;
    logic [63:0]     prod_reg, prod_next;
    logic            bad_reg, bad_next;
    logic [CLRW-1:0] clr_cnt_reg, clr_cnt_next;
    logic            clr_full_reg, clr_full_next;
    logic [30:0]     p_init_reg;
    logic [CW-1:0]   n_reg, m_reg;
    logic            out_vld_reg;
    logic [2:0]      out_idx_reg;
    logic [31:0]     out_est_reg;
    logic            out_last_reg;
    logic            out_npd_reg;

    // store
    logic [31:0]     mem [DEPTH];
    logic [31:0]     rda_reg, rdb_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, ra, rb;
    logic [31:0]     mem_wdata;

    // per-phase loop description
    logic [CW-1:0]   o_lim, mid_lim;
    logic [KW-1:0]   klen;
    logic [AW-1:0]   init_a, init_b, mac_a, mac_b, dest_addr;
    logic [KW-1:0]   diag;
    init_t           init_sel;
    fin_t            fin;
    logic            mac_sub;
    logic [KW-1:0]   oo, mm, ib, kb, kn;

    logic            s_acc;
    logic [2:0]      ld_row, ld_col;
    logic [31:0]     ld_val;
    logic [31:0]     sat_acc;
    logic            k_last, mid_last, o_last, emit_last, is_diag, piv_bad, out_free;
    logic [2*DB-1:0] clr_rc;
    logic            clr_end;
    logic [63:0]     prod_sh;
    ds_req_t         ds_req;
    ds_rsp_t         ds_rsp;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign ld_row   = s_tdata[2:0];
    assign ld_col   = s_tdata[5:3];
    assign ld_val   = s_tdata[37:6];
    assign sat_acc  = sat32(acc_reg);
    assign oo       = KW'(o_reg);
    assign mm       = KW'(mi_reg);
    assign ib       = KW'(m_reg) - KW'(1) - mm;
    assign kb       = ib + KW'(1) + k_reg;
    assign kn       = k_reg - KW'(n_reg);
    assign prod_sh  = $signed(prod_reg) >>> FRAC_BITS;

    assign k_last    = (k_reg + KW'(1)) == klen;
    assign mid_last  = CW'(mi_reg + CW'(1)) == mid_lim;
    assign o_last    = CW'(o_reg + CW'(1)) == o_lim;
    assign emit_last = CW'(o_reg + CW'(1)) == n_reg;
    assign is_diag   = (mi_reg == o_reg);
    assign piv_bad   = sat_acc[31] || (sat_acc == 32'd0);
    assign out_free  = !out_vld_reg || m_tready;

    assign clr_rc  = clr_cnt_reg[2*DB-1:0];
    assign clr_end = clr_full_reg ? (&clr_cnt_reg) : (&clr_rc);

    // loop bounds and addresses of the current phase
    always_comb
    begin
        o_lim     = n_reg;
        mid_lim   = n_reg;
        klen      = KW'(n_reg);
        init_a    = ad(REG_P, oo, mm);
        init_b    = ad(REG_Q, oo, mm);
        mac_a     = ad(REG_A, oo, k_reg);
        mac_b     = ad(REG_PW, k_reg, mm);
        dest_addr = ad(REG_PW, oo, mm);
        diag      = oo;
        init_sel  = INIT_ZERO;
        fin       = FIN_STORE;
        mac_sub   = 1'b0;
        unique case (phase_reg)
            PH_PQ:
            begin
                klen     = '0;
                init_sel = INIT_AB;
            end
            PH_AP:
            begin
                o_lim     = m_reg;
                dest_addr = ad(REG_AP, oo, mm);
            end
            PH_S:
            begin
                o_lim     = m_reg;
                mid_lim   = CW'(o_reg + CW'(1));
                init_a    = ad(REG_R, oo, mm);
                init_sel  = INIT_A;
                mac_a     = ad(REG_AP, oo, k_reg);
                mac_b     = ad(REG_A, mm, k_reg);
                dest_addr = ad(REG_S, oo, mm);
            end
            PH_CHOL:
            begin
                o_lim     = m_reg;
                mid_lim   = m_reg;
                klen      = oo;
                init_a    = ad(REG_S, mm, oo);
                init_sel  = INIT_A;
                mac_a     = ad(REG_L, mm, k_reg);
                mac_b     = ad(REG_L, oo, k_reg);
                mac_sub   = 1'b1;
                dest_addr = ad(REG_L, mm, oo);
                fin       = FIN_CHOL;
            end
            PH_FWD:
            begin
                mid_lim   = m_reg;
                klen      = mm;
                init_a    = ad(REG_AP, mm, oo);
                init_sel  = INIT_A;
                mac_a     = ad(REG_L, mm, k_reg);
                mac_b     = ad(REG_Y, k_reg, oo);
                mac_sub   = 1'b1;
                dest_addr = ad(REG_Y, mm, oo);
                diag      = mm;
                fin       = FIN_DIV;
            end
            PH_BWD:
            begin
                // rows run from the bottom up
                mid_lim   = m_reg;
                klen      = mm;
                init_a    = ad(REG_Y, ib, oo);
                init_sel  = INIT_A;
                mac_a     = ad(REG_L, kb, ib);
                mac_b     = ad(REG_Z, kb, oo);
                mac_sub   = 1'b1;
                dest_addr = ad(REG_Z, ib, oo);
                diag      = ib;
                fin       = FIN_DIV;
            end
            PH_INNOV:
            begin
                o_lim     = m_reg;
                mid_lim   = CW'(1);
                init_a    = ad(REG_B, '0, oo);
                init_sel  = INIT_A;
                mac_a     = ad(REG_A, oo, k_reg);
                mac_b     = ad(REG_X, '0, k_reg);
                mac_sub   = 1'b1;
                dest_addr = ad(REG_IN, '0, oo);
            end
            PH_XN:
            begin
                mid_lim   = CW'(1);
                klen      = KW'(m_reg);
                init_a    = ad(REG_X, '0, oo);
                init_sel  = INIT_A;
                mac_a     = ad(REG_Z, k_reg, oo);
                mac_b     = ad(REG_IN, '0, k_reg);
                dest_addr = ad(REG_X, '0, oo);
            end
            PH_IKH:
            begin
                klen      = KW'(m_reg);
                init_sel  = INIT_EYE;
                mac_a     = ad(REG_Z, k_reg, oo);
                mac_b     = ad(REG_A, k_reg, mm);
                mac_sub   = 1'b1;
                dest_addr = ad(REG_IKH, oo, mm);
            end
            PH_T:
            begin
                mac_a     = ad(REG_IKH, oo, k_reg);
                mac_b     = ad(REG_PW, k_reg, mm);
                dest_addr = ad(REG_T, oo, mm);
            end
            PH_KR:
            begin
                mid_lim   = m_reg;
                klen      = KW'(m_reg);
                mac_a     = ad(REG_Z, k_reg, oo);
                mac_b     = ad(REG_R, k_reg, mm);
                dest_addr = ad(REG_KR, oo, mm);
            end
            PH_PN:
            begin
                // T IKH^T terms first, then KR K^T terms
                klen      = KW'(n_reg) + KW'(m_reg);
                if (k_reg < KW'(n_reg))
                begin
                    mac_a = ad(REG_T, oo, k_reg);
                    mac_b = ad(REG_IKH, mm, k_reg);
                end
                else
                begin
                    mac_a = ad(REG_KR, oo, kn);
                    mac_b = ad(REG_Z, kn, mm);
                end
                dest_addr = ad(REG_P, oo, mm);
            end
            default:
            begin
                klen = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:     if (clr_end) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (s_acc && (s_tuser == CMD_RUN)) state_next = ST_INIT_RD;
                else if (s_acc && (s_tuser == CMD_RESET_P)) state_next = ST_CLR;
            end
            ST_INIT_RD: state_next = ST_INIT_AC;
            ST_INIT_AC: state_next = (klen == '0) ? ST_FIN : ST_MAC_RD;
            ST_MAC_RD:  state_next = ST_MAC_MUL;
            ST_MAC_MUL: state_next = ST_MAC_ACC;
            ST_MAC_ACC: state_next = k_last ? ST_FIN : ST_MAC_RD;
            ST_FIN:
            begin
                priority if (fin == FIN_STORE) state_next = ST_NEXT;
                else if (fin == FIN_CHOL && is_diag)
                    state_next = piv_bad ? ST_EMIT_RD : ST_DS_GO;
                else state_next = ST_DIAG_RD;
            end
            ST_DIAG_RD: state_next = ST_DS_GO;
            ST_DS_GO:   state_next = ST_DS_WAIT;
            ST_DS_WAIT: if (ds_rsp.done) state_next = ST_NEXT;
            ST_NEXT:
            begin
                if (mid_last && o_last && phase_reg == PH_PN) state_next = ST_EMIT_RD;
                else state_next = ST_INIT_RD;
            end
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD:
            begin
                if (out_free) state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and store access
    always_comb
    begin
        phase_next    = phase_reg;
        o_next        = o_reg;
        mi_next       = mi_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        bad_next      = bad_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_full_next = clr_full_reg;
        mem_we        = 1'b0;
        mem_waddr     = dest_addr;
        mem_wdata     = sat_acc;
        ra            = init_a;
        rb            = init_b;
        ds_req        = '{start: 1'b0, mode: DS_DIV, num: sat_acc, den: rdb_reg};
        unique case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {2'b00, clr_cnt_reg[CLRW-1 -: 2], clr_rc};
                mem_wdata = '0;
                if (clr_cnt_reg[CLRW-1 -: 2] == 2'b00 &&
                    clr_rc[2*DB-1:DB] == clr_rc[DB-1:0])
                    mem_wdata = clr_full_reg ? {1'b0, P_INIT_RST} : {1'b0, p_init_reg};
                clr_cnt_next = clr_cnt_reg + CLRW'(1);
            end
            ST_IDLE:
            begin
                o_next       = '0;
                mi_next      = '0;
                phase_next   = PH_PQ;
                bad_next     = 1'b0;
                clr_cnt_next = '0;
                mem_wdata    = ld_val;
                if (s_acc)
                begin
                    unique case (s_tuser)
                        CMD_LOAD_Q:
                        begin
                            mem_we    = (int'(ld_row) < MAX_STATE) && (int'(ld_col) < MAX_STATE);
                            mem_waddr = ad(REG_Q, KW'(ld_row), KW'(ld_col));
                        end
                        CMD_LOAD_R:
                        begin
                            mem_we    = (int'(ld_row) < MAX_MEAS) && (int'(ld_col) < MAX_MEAS);
                            mem_waddr = ad(REG_R, KW'(ld_row), KW'(ld_col));
                        end
                        CMD_LOAD_X:
                        begin
                            mem_we    = int'(ld_row) < MAX_STATE;
                            mem_waddr = ad(REG_X, '0, KW'(ld_row));
                        end
                        CMD_LOAD_A:
                        begin
                            mem_we    = (int'(ld_row) < MAX_MEAS) && (int'(ld_col) < MAX_STATE);
                            mem_waddr = ad(REG_A, KW'(ld_row), KW'(ld_col));
                        end
                        CMD_LOAD_B:
                        begin
                            mem_we    = int'(ld_row) < MAX_MEAS;
                            mem_waddr = ad(REG_B, '0, KW'(ld_row));
                        end
                        CMD_RESET_P:
                        begin
                            clr_full_next = 1'b0;
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_INIT_AC:
            begin
                k_next = '0;
                unique case (init_sel)
                    INIT_ZERO: acc_next = '0;
                    INIT_A:    acc_next = {{32{rda_reg[31]}}, rda_reg};
                    INIT_AB:   acc_next = {{32{rda_reg[31]}}, rda_reg} +
                                          {{32{rdb_reg[31]}}, rdb_reg};
                    default:   acc_next = is_diag ? ONE : '0;
                endcase
            end
            ST_MAC_RD:
            begin
                ra = mac_a;
                rb = mac_b;
            end
            ST_MAC_MUL:
            begin
                prod_next = 64'($signed(rda_reg) * $signed(rdb_reg));
            end
            ST_MAC_ACC:
            begin
                acc_next = mac_sub ? (acc_reg - prod_sh) : (acc_reg + prod_sh);
                k_next   = k_reg + KW'(1);
            end
            ST_FIN:
            begin
                mem_we = (fin == FIN_STORE);
                if (fin == FIN_CHOL && is_diag && piv_bad)
                begin
                    bad_next = 1'b1;
                    o_next   = '0;
                end
            end
            ST_DIAG_RD:
            begin
                rb = ad(REG_L, diag, diag);
            end
            ST_DS_GO:
            begin
                ds_req.start = 1'b1;
                ds_req.mode  = (fin == FIN_CHOL && is_diag) ? DS_SQRT : DS_DIV;
            end
            ST_DS_WAIT:
            begin
                mem_we    = ds_rsp.done;
                mem_wdata = ds_rsp.res;
            end
            ST_NEXT:
            begin
                if (!mid_last)
                begin
                    mi_next = CW'(mi_reg + CW'(1));
                end
                else if (!o_last)
                begin
                    o_next  = CW'(o_reg + CW'(1));
                    mi_next = (phase_reg == PH_CHOL) ? CW'(o_reg + CW'(1)) : '0;
                end
                else
                begin
                    o_next     = '0;
                    mi_next    = '0;
                    phase_next = phase_t'(4'(phase_reg) + 4'd1);
                end
            end
            ST_EMIT_RD:
            begin
                ra = ad(REG_X, '0, oo);
            end
            ST_EMIT_LD:
            begin
                ra = ad(REG_X, '0, oo);
                if (out_free && !emit_last) o_next = CW'(o_reg + CW'(1));
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            phase_reg    <= PH_PQ;
            o_reg        <= '0;
            mi_reg       <= '0;
            k_reg        <= '0;
            bad_reg      <= 1'b0;
            clr_cnt_reg  <= '0;
            clr_full_reg <= 1'b1;
            p_init_reg   <= P_INIT_RST;
            n_reg        <= CW'(MAX_STATE);
            m_reg        <= CW'(MAX_MEAS);
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            o_reg        <= o_next;
            mi_reg       <= mi_next;
            k_reg        <= k_next;
            bad_reg      <= bad_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_full_reg <= clr_full_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_P_INIT: p_init_reg <= cfg_wdata;
                    CFG_N_STATE:
                    begin
                        if (cfg_wdata[3:0] == 4'd0) n_reg <= CW'(1);
                        else if (int'(cfg_wdata[3:0]) > MAX_STATE) n_reg <= CW'(MAX_STATE);
                        else n_reg <= CW'(cfg_wdata[3:0]);
                    end
                    CFG_N_MEAS:
                    begin
                        if (cfg_wdata[3:0] == 4'd0) m_reg <= CW'(1);
                        else if (int'(cfg_wdata[3:0]) > MAX_MEAS) m_reg <= CW'(MAX_MEAS);
                        else m_reg <= CW'(cfg_wdata[3:0]);
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_EMIT_LD && out_free) out_vld_reg <= 1'b1;
            else if (m_tready) out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        if (state_reg == ST_EMIT_LD && out_free)
        begin
            out_idx_reg  <= 3'(o_reg);
            out_est_reg  <= rda_reg;
            out_last_reg <= emit_last;
            out_npd_reg  <= bad_reg;
        end
    end

    // matrix store, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rda_reg <= mem[ra];
        rdb_reg <= mem[rb];
    end

    kuj_divsqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ds_req),
        .rsp   (ds_rsp)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_est_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_npd_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ds_rsp.done |-> state_reg == ST_DS_WAIT)
        else $error("divide/sqrt result arrived outside its wait state");

    a_bad_from_chol: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bad_reg) |-> $past(phase_reg) == PH_CHOL)
        else $error("pivot failure flagged outside the factorisation");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !s_tvalid) |-> !mem_we)
        else $error("store written while idle with no word offered");

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// kalman update testbench
// Drives load and run commands into the Joseph-form Kalman update block,
// predicts every emitted state word with a fixed-point model of its own and
// checks the stream in order, with random bursts and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import kuj_pkg::*;

    localparam int DIM = 8;
    localparam int FB = 16;
    localparam int WATCHDOG = 400000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] estimate;
        logic        last;
        logic        not_pd;
    } state_word_t;

    // directed row: has_exp marks runs whose not_pd flag is typed in
    typedef struct {
        cmd_word_t   w;
        logic        has_exp;
        logic        exp_npd;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [30:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    kalman_update_joseph_form u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [30:0] k_pinit;
    int          k_n, k_m;
    int signed   cov[DIM][DIM], qn[DIM][DIM], rn[DIM][DIM];
    int signed   xv[DIM], am[DIM][DIM], bv[DIM];

    state_word_t expected_words[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          stall_on = 1'b0;

    function automatic int signed sat(longint signed v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    // product of two fixed values, floor rounding (arithmetic shift)
    function automatic longint signed fmul(int signed a, int signed b);
        longint signed p;
        p = longint'(a) * longint'(b);
        return p >>> FB;
    endfunction

    function automatic int signed fdiv(longint signed a, int signed d);
        longint signed num;
        num = longint'(sat(a)) * (64'sd1 <<< FB);
        return sat(num / longint'(d));
    endfunction

    function automatic int signed fsqrt(int signed d);
        longint unsigned v, r, b;
        v = longint'(unsigned'(d)) << FB;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return int'(r);
    endfunction

    function automatic int clamp_dim(logic [3:0] v);
        if (v == 0) return 1;
        if (v > DIM) return DIM;
        return int'(v);
    endfunction

    task automatic preset_cov();
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM; c++)
                cov[r][c] = (r == c) ? int'({1'b0, k_pinit}) : 0;
    endtask

    task automatic apply_cfg(logic [1:0] addr, logic [30:0] data);
        if (addr == CFG_P_INIT) k_pinit = data;
        else if (addr == CFG_N_STATE) k_n = clamp_dim(data[3:0]);
        else if (addr == CFG_N_MEAS) k_m = clamp_dim(data[3:0]);
    endtask

    // kalman measurement update; pushes the emitted state words
    task automatic predict_update();
        int signed pp[DIM][DIM], ap[DIM][DIM], s[DIM][DIM], l[DIM][DIM];
        int signed y[DIM][DIM], z[DIM][DIM], ikh[DIM][DIM], t[DIM][DIM];
        int signed kr[DIM][DIM], innov[DIM], xn[DIM];
        longint signed acc;
        int signed d;
        bit bad;
        state_word_t w;
        bad = 0;
        for (int r = 0; r < k_n; r++)
            for (int c = 0; c < k_n; c++)
                pp[r][c] = sat(longint'(cov[r][c]) + qn[r][c]);
        for (int i = 0; i < k_m; i++)
            for (int c = 0; c < k_n; c++)
            begin
                acc = 0;
                for (int k = 0; k < k_n; k++) acc += fmul(am[i][k], pp[k][c]);
                ap[i][c] = sat(acc);
            end
        for (int i = 0; i < k_m; i++)
            for (int j = 0; j <= i; j++)
            begin
                acc = rn[i][j];
                for (int k = 0; k < k_n; k++) acc += fmul(ap[i][k], am[j][k]);
                s[i][j] = sat(acc);
            end
        for (int j = 0; j < k_m && !bad; j++)
        begin
            acc = s[j][j];
            for (int k = 0; k < j; k++) acc -= fmul(l[j][k], l[j][k]);
            d = sat(acc);
            if (d <= 0) bad = 1;
            else
            begin
                l[j][j] = fsqrt(d);
                for (int i = j + 1; i < k_m; i++)
                begin
                    acc = s[i][j];
                    for (int k = 0; k < j; k++) acc -= fmul(l[i][k], l[j][k]);
                    l[i][j] = fdiv(acc, l[j][j]);
                end
            end
        end
        if (!bad)
        begin
            for (int c = 0; c < k_n; c++)
            begin
                for (int i = 0; i < k_m; i++)
                begin
                    acc = ap[i][c];
                    for (int k = 0; k < i; k++) acc -= fmul(l[i][k], y[k][c]);
                    y[i][c] = fdiv(acc, l[i][i]);
                end
                for (int i = k_m - 1; i >= 0; i--)
                begin
                    acc = y[i][c];
                    for (int k = i + 1; k < k_m; k++) acc -= fmul(l[k][i], z[k][c]);
                    z[i][c] = fdiv(acc, l[i][i]);
                end
            end
            for (int i = 0; i < k_m; i++)
            begin
                acc = bv[i];
                for (int k = 0; k < k_n; k++) acc -= fmul(am[i][k], xv[k]);
                innov[i] = sat(acc);
            end
            for (int r = 0; r < k_n; r++)
            begin
                acc = xv[r];
                for (int i = 0; i < k_m; i++) acc += fmul(z[i][r], innov[i]);
                xn[r] = sat(acc);
            end
            for (int r = 0; r < k_n; r++)
                for (int c = 0; c < k_n; c++)
                begin
                    acc = (r == c) ? (64'sd1 <<< FB) : 0;
                    for (int i = 0; i < k_m; i++) acc -= fmul(z[i][r], am[i][c]);
                    ikh[r][c] = sat(acc);
                end
            for (int r = 0; r < k_n; r++)
                for (int c = 0; c < k_n; c++)
                begin
                    acc = 0;
                    for (int k = 0; k < k_n; k++) acc += fmul(ikh[r][k], pp[k][c]);
                    t[r][c] = sat(acc);
                end
            for (int r = 0; r < k_n; r++)
                for (int c = 0; c < k_m; c++)
                begin
                    acc = 0;
                    for (int i = 0; i < k_m; i++) acc += fmul(z[i][r], rn[i][c]);
                    kr[r][c] = sat(acc);
                end
            for (int r = 0; r < k_n; r++)
                for (int c = 0; c < k_n; c++)
                begin
                    acc = 0;
                    for (int k = 0; k < k_n; k++) acc += fmul(t[r][k], ikh[c][k]);
                    for (int i = 0; i < k_m; i++) acc += fmul(kr[r][i], z[i][c]);
                    cov[r][c] = sat(acc);
                end
            for (int r = 0; r < k_n; r++) xv[r] = xn[r];
        end
        for (int r = 0; r < k_n; r++)
        begin
            w.index = r[2:0];
            w.estimate = xv[r];
            w.last = (r == k_n - 1);
            w.not_pd = bad;
            expected_words.push_back(w);
        end
    endtask

    task automatic predict_word(cmd_word_t w);
        int signed v;
        v = w.value;
        case (w.cmd)
            CMD_LOAD_Q: qn[w.row][w.col] = v;
            CMD_LOAD_R: rn[w.row][w.col] = v;
            CMD_LOAD_X: xv[w.row] = v;
            CMD_LOAD_A: am[w.row][w.col] = v;
            CMD_LOAD_B: bv[w.row] = v;
            CMD_RESET_P: preset_cov();
            CMD_RUN: predict_update();
            default: ;
        endcase
    endtask

    // send one command word, in bursts with random gaps
    int burst_left = 0;
    task automatic send_word(cmd_word_t w);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.cmd;
        s_tdata <= {2'b00, w.value, w.col, w.row};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_word(w);
        burst_left--;
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain();
        idle_sender();
        while (expected_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] addr, logic [30:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_cfg(addr, data);
    endtask

    function automatic cmd_word_t mk(logic [2:0] c, logic [2:0] r, logic [2:0] k,
                                     logic [31:0] v);
        cmd_word_t w;
        w.cmd = c; w.row = r; w.col = k; w.value = v;
        return w;
    endfunction

    // receiver stall pattern and output checking
    always @(posedge clk)
    begin
        state_word_t got, exp_w;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.index = m_tdata[2:0];
                got.estimate = m_tdata[34:3];
                got.last = m_tlast;
                got.not_pd = m_tuser;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, got);
                    errors++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w)
                    begin
                        $display("%0t: mismatch expected idx %0d est %h last %b npd %b,"
                                 , $time, exp_w.index, exp_w.estimate, exp_w.last,
                                 exp_w.not_pd);
                        $display("%0t:   actual idx %0d est %h last %b npd %b", $time,
                                 got.index, got.estimate, got.last, got.not_pd);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
            m_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // random well-conditioned problem with random content
    task automatic load_problem();
        for (int i = 0; i < k_m; i++)
        begin
            for (int c = 0; c < k_n; c++)
                send_word(mk(CMD_LOAD_A, i[2:0], c[2:0],
                             $urandom_range(0, 3) == 0 ? $urandom_range(0, 131072) - 65536 : 0));
            send_word(mk(CMD_LOAD_B, i[2:0], 3'($urandom),
                         $urandom_range(0, 1 << 20) - (1 << 19)));
            send_word(mk(CMD_LOAD_R, i[2:0], i[2:0], $urandom_range(16384, 262144)));
        end
    endtask

    row_t dir[$];
    cmd_word_t rw;
    int items;

    initial
    begin
        k_pinit = P_INIT_RST; k_n = 8; k_m = 8;
        preset_cov();
        for (int r = 0; r < DIM; r++)
        begin
            xv[r] = 0; bv[r] = 0;
            for (int c = 0; c < DIM; c++)
            begin
                qn[r][c] = 0; rn[r][c] = 0; am[r][c] = 0;
            end
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small sizes first; A and b written before any run
        write_cfg(CFG_N_STATE, 31'd2);
        write_cfg(CFG_N_MEAS, 31'd1);
        write_cfg(CFG_P_INIT, 31'h7fff_ffff);
        dir.push_back('{mk(CMD_RESET_P, 0, 0, 0), 0, 0});
        dir.push_back('{mk(CMD_LOAD_A, 0, 0, 32'h0001_0000), 0, 0});
        dir.push_back('{mk(CMD_LOAD_A, 0, 1, 0), 0, 0});
        dir.push_back('{mk(CMD_LOAD_B, 0, 0, 32'h7fff_ffff), 0, 0});
        dir.push_back('{mk(CMD_LOAD_X, 0, 0, 32'h8000_0000), 0, 0});
        dir.push_back('{mk(CMD_LOAD_X, 1, 0, 32'h7fff_ffff), 0, 0});
        dir.push_back('{mk(CMD_LOAD_Q, 7, 7, 32'hffff_ffff), 0, 0});
        dir.push_back('{mk(CMD_LOAD_R, 7, 7, 32'h8000_0000), 0, 0});
        dir.push_back('{mk(3'd7, 7, 7, 32'h1234_5678), 0, 0});
        dir.push_back('{mk(CMD_RUN, 0, 0, 0), 0, 0});
        // negative R makes the pivot non-positive with A zero
        dir.push_back('{mk(CMD_LOAD_A, 0, 0, 0), 0, 0});
        dir.push_back('{mk(CMD_LOAD_R, 0, 0, 32'hffff_0000), 0, 0});
        dir.push_back('{mk(CMD_RUN, 0, 0, 0), 1, 1});
        dir.push_back('{mk(CMD_LOAD_R, 0, 0, 0), 0, 0});
        dir.push_back('{mk(CMD_RUN, 0, 0, 0), 1, 1});
        dir.push_back('{mk(CMD_LOAD_R, 0, 0, 32'h0001_0000), 0, 0});
        dir.push_back('{mk(CMD_LOAD_A, 0, 1, 32'h8000_0000), 0, 0});
        dir.push_back('{mk(CMD_RUN, 0, 0, 0), 0, 0});
        foreach (dir[i])
        begin
            send_word(dir[i].w);
            if (dir[i].has_exp)
            begin
                // pivot failure: every word of this run carries the not_pd flag
                for (int j = expected_words.size() - k_n; j < expected_words.size(); j++)
                    if (expected_words[j].not_pd !== dir[i].exp_npd)
                    begin
                        $display("%0t: mismatch expected not_pd %b actual prediction %b",
                                 $time, dir[i].exp_npd, expected_words[j].not_pd);
                        errors++;
                    end
            end
        end
        drain();

        // random phases over several sizes, extremes among them
        items = 0;
        for (int ph = 0; items < 410; ph++)
        begin
            write_cfg(CFG_N_STATE, ph == 0 ? 31'd0 : ph == 1 ? 31'd15 :
                      ph == 2 ? 31'd8 : 31'($urandom_range(1, 3)));
            write_cfg(CFG_N_MEAS, ph == 0 ? 31'd0 : ph == 1 ? 31'd15 :
                      ph == 2 ? 31'd8 : 31'($urandom_range(1, 3)));
            write_cfg(CFG_P_INIT, ph == 3 ? 31'd0 : 31'($urandom_range(1 << 14, 1 << 19)));
            send_word(mk(CMD_RESET_P, 3'($urandom), 3'($urandom), $urandom));
            load_problem();
            for (int u = 0; u < 4; u++)
            begin
                if ($urandom_range(0, 3) == 0)
                    rw = mk($urandom_range(0, 2) == 0 ? 3'd7 : CMD_LOAD_Q,
                            3'($urandom), 3'($urandom), $urandom);
                else
                    rw = mk(CMD_LOAD_X, 3'($urandom), 3'($urandom),
                            $urandom_range(0, 1 << 22) - (1 << 21));
                send_word(rw);
                send_word(mk(CMD_LOAD_B, 3'($urandom_range(0, k_m - 1)), 0, $urandom));
                send_word(mk(CMD_RUN, 3'($urandom), 3'($urandom), $urandom));
                items += 3;
            end
            items += k_m * (k_n + 2) + 1;
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
